// ===== hdl/sers_pkg.sv =====
// Package for the spring edge relaxation step: fixed-point widths and pipeline word types.
// It has no dependencies. The interfaces and the top level import it.
`default_nettype none
package sers_pkg;

  // coordinate format
  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 8;
  localparam int REST_W    = 12;

  // derived widths
  localparam int DIFF_W   = COORD_W + 1;              // to - from
  localparam int MAG_W    = COORD_W;                  // |to - from|
  localparam int SQ_W     = 2 * MAG_W + 1;            // vx^2 + vy^2
  localparam int LEN_W    = MAG_W + 1;                // floor sqrt
  localparam int SQT_W    = 2 * LEN_W + 1;            // sqrt remainder
  localparam int RESTQ_W  = REST_W + FRAC_BITS;
  localparam int DLT_W    = ((RESTQ_W > LEN_W) ? RESTQ_W : LEN_W) + 1;  // rest_q - len
  localparam int DMAG_W   = DLT_W;
  localparam int PROD_W   = MAG_W + DMAG_W;
  localparam int DVS_W    = LEN_W + 2;                // 3 * len
  localparam int QUO_W    = DMAG_W;
  localparam int DV_W     = DVS_W + QUO_W;            // division remainder
  localparam int SUM_W    = ((COORD_W > QUO_W + 1) ? COORD_W : QUO_W + 1) + 1;

  // word in flight through the front and the square root stages
  typedef struct packed {
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [DIFF_W-1:0]  vx;
    logic signed [DIFF_W-1:0]  vy;
    logic [RESTQ_W-1:0]        rest_q;
  } front_t;

  // word in flight through the divider stages
  typedef struct packed {
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic                      neg_x;
    logic                      neg_y;
    logic                      zero;
    logic [DVS_W-1:0]          dvs;
  } back_t;

endpackage
`default_nettype wire

// ===== hdl/sers_in_if.sv =====
// Input channel of the spring edge relaxation step: one edge word.
// Depends on sers_pkg.
`default_nettype none
interface sers_in_if
  import sers_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] from_x;
  logic signed [COORD_W-1:0] from_y;
  logic signed [COORD_W-1:0] to_x;
  logic signed [COORD_W-1:0] to_y;
  logic [REST_W-1:0]         rest_length;

  modport source (output valid, from_x, from_y, to_x, to_y, rest_length, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, rest_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/sers_out_if.sv =====
// Output channel of the spring edge relaxation step: moved endpoints and clamp flag.
// Depends on sers_pkg.
`default_nettype none
interface sers_out_if
  import sers_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] new_from_x;
  logic signed [COORD_W-1:0] new_from_y;
  logic signed [COORD_W-1:0] new_to_x;
  logic signed [COORD_W-1:0] new_to_y;
  logic                      saturated;

  modport source (output valid, new_from_x, new_from_y, new_to_x, new_to_y, saturated,
                  input ready);
  modport sink   (input valid, new_from_x, new_from_y, new_to_x, new_to_y, saturated,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/spring_edge_relax_step_top.sv =====
// Spring edge relaxation step: subtract, square, bit-serial square root, multiply,
// restoring divide and saturate, all as one stall-together pipeline. Depends on sers_pkg.
//
// One edge word is accepted every cycle while the output is free or being taken; the
// rate is one word per cycle. There is one stage per square root bit and one per
// quotient bit. A stall at the output freezes the whole pipeline, so ready falls
// only while a result waits.
`default_nettype none
module spring_edge_relax_step_top
  import sers_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  sers_in_if.sink     req,
  sers_out_if.source  rsp
);

  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // stage A: capture and form the edge vector
  front_t a_item;
  logic   a_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= req.valid;
    end
    if (en) begin
      a_item.fx     <= req.from_x;
      a_item.fy     <= req.from_y;
      a_item.tx     <= req.to_x;
      a_item.ty     <= req.to_y;
      a_item.vx     <= DIFF_W'(req.to_x) - DIFF_W'(req.from_x);
      a_item.vy     <= DIFF_W'(req.to_y) - DIFF_W'(req.from_y);
      a_item.rest_q <= RESTQ_W'(req.rest_length) << FRAC_BITS;
    end
  end

  // stage B: squares of the magnitudes
  logic [MAG_W-1:0] a_mx, a_my;
  assign a_mx = a_item.vx[DIFF_W-1] ? MAG_W'(-a_item.vx) : MAG_W'(a_item.vx);
  assign a_my = a_item.vy[DIFF_W-1] ? MAG_W'(-a_item.vy) : MAG_W'(a_item.vy);

  front_t b_item;
  logic   b_v;
  logic [2*MAG_W-1:0] b_sqx, b_sqy;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
    if (en) begin
      b_item <= a_item;
      b_sqx  <= a_mx * a_mx;
      b_sqy  <= a_my * a_my;
    end
  end

  // stage C: sum of squares feeds the root stages
  logic [SQT_W-1:0] sr_rem  [0:LEN_W];
  logic [LEN_W-1:0] sr_res  [0:LEN_W];
  front_t           sr_item [0:LEN_W];
  logic             sr_v    [0:LEN_W];
  always_ff @(posedge clk) begin
    if (rst) begin
      sr_v[0] <= 1'b0;
    end else if (en) begin
      sr_v[0] <= b_v;
    end
    if (en) begin
      sr_rem[0]  <= SQT_W'(SQ_W'(b_sqx) + SQ_W'(b_sqy));
      sr_res[0]  <= '0;
      sr_item[0] <= b_item;
    end
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
    localparam int B = LEN_W - 1 - k;
    logic [SQT_W-1:0] trial;
    logic             take;
    assign trial = (SQT_W'(sr_res[k]) << (B + 1)) + (SQT_W'(1) << (2 * B));
    assign take  = sr_rem[k] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[k+1] <= 1'b0;
      end else if (en) begin
        sr_v[k+1] <= sr_v[k];
      end
      if (en) begin
        sr_rem[k+1]  <= take ? sr_rem[k] - trial : sr_rem[k];
        sr_res[k+1]  <= take ? (sr_res[k] | (LEN_W'(1) << B)) : sr_res[k];
        sr_item[k+1] <= sr_item[k];
      end
    end
  end

  // stage D: signed length error, split into magnitude and sign
  logic [LEN_W-1:0]        len;
  logic signed [DLT_W-1:0] dlt;
  assign len = sr_res[LEN_W];
  assign dlt = $signed(DLT_W'(sr_item[LEN_W].rest_q)) - $signed(DLT_W'(len));

  front_t            d_item;
  logic              d_v;
  logic [LEN_W-1:0]  d_len;
  logic [DMAG_W-1:0] d_dmag;
  logic              d_dneg;
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= sr_v[LEN_W];
    end
    if (en) begin
      d_item <= sr_item[LEN_W];
      d_len  <= len;
      d_dmag <= dlt[DLT_W-1] ? DMAG_W'(-dlt) : DMAG_W'(dlt);
      d_dneg <= dlt[DLT_W-1];
    end
  end

  // stage E: products and divisor, start of the divider
  logic [MAG_W-1:0] d_mx, d_my;
  assign d_mx = d_item.vx[DIFF_W-1] ? MAG_W'(-d_item.vx) : MAG_W'(d_item.vx);
  assign d_my = d_item.vy[DIFF_W-1] ? MAG_W'(-d_item.vy) : MAG_W'(d_item.vy);

  logic [DV_W-1:0]  dv_remx [0:QUO_W];
  logic [DV_W-1:0]  dv_remy [0:QUO_W];
  logic [QUO_W-1:0] dv_qx   [0:QUO_W];
  logic [QUO_W-1:0] dv_qy   [0:QUO_W];
  back_t            dv_ctl  [0:QUO_W];
  logic             dv_v    [0:QUO_W];
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= d_v;
    end
    if (en) begin
      dv_remx[0]      <= DV_W'(d_mx * d_dmag);
      dv_remy[0]      <= DV_W'(d_my * d_dmag);
      dv_qx[0]        <= '0;
      dv_qy[0]        <= '0;
      dv_ctl[0].fx    <= d_item.fx;
      dv_ctl[0].fy    <= d_item.fy;
      dv_ctl[0].tx    <= d_item.tx;
      dv_ctl[0].ty    <= d_item.ty;
      dv_ctl[0].neg_x <= d_item.vx[DIFF_W-1] ^ d_dneg;
      dv_ctl[0].neg_y <= d_item.vy[DIFF_W-1] ^ d_dneg;
      dv_ctl[0].zero  <= (d_len == '0);
      dv_ctl[0].dvs   <= DVS_W'(d_len) + (DVS_W'(d_len) << 1);
    end
  end

  // one quotient bit per stage for both axes
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int I = QUO_W - 1 - j;
    logic [DV_W-1:0] sh;
    logic            tx_take, ty_take;
    assign sh      = DV_W'(dv_ctl[j].dvs) << I;
    assign tx_take = dv_remx[j] >= sh;
    assign ty_take = dv_remy[j] >= sh;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        dv_remx[j+1] <= tx_take ? dv_remx[j] - sh : dv_remx[j];
        dv_remy[j+1] <= ty_take ? dv_remy[j] - sh : dv_remy[j];
        dv_qx[j+1]   <= {dv_qx[j][QUO_W-2:0], tx_take};
        dv_qy[j+1]   <= {dv_qy[j][QUO_W-2:0], ty_take};
        dv_ctl[j+1]  <= dv_ctl[j];
      end
    end
  end

  // stage F: apply displacement and clamp
  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] C_MIN = -C_MAX - SUM_W'(1);

  function automatic logic [COORD_W:0] clamp(input logic signed [SUM_W-1:0] v);
    logic [COORD_W:0] r;
    if (v > C_MAX) begin
      r = {1'b1, C_MAX[COORD_W-1:0]};
    end else if (v < C_MIN) begin
      r = {1'b1, C_MIN[COORD_W-1:0]};
    end else begin
      r = {1'b0, v[COORD_W-1:0]};
    end
    return r;
  endfunction

  back_t                   f_ctl;
  logic signed [SUM_W-1:0] dxs, dys;
  logic [COORD_W:0]        c_fx, c_fy, c_tx, c_ty;
  assign f_ctl = dv_ctl[QUO_W];
  assign dxs = f_ctl.zero ? '0 : f_ctl.neg_x ? -$signed(SUM_W'(dv_qx[QUO_W]))
                                             : $signed(SUM_W'(dv_qx[QUO_W]));
  assign dys = f_ctl.zero ? '0 : f_ctl.neg_y ? -$signed(SUM_W'(dv_qy[QUO_W]))
                                             : $signed(SUM_W'(dv_qy[QUO_W]));
  assign c_fx = clamp(SUM_W'(f_ctl.fx) - dxs);
  assign c_fy = clamp(SUM_W'(f_ctl.fy) - dys);
  assign c_tx = clamp(SUM_W'(f_ctl.tx) + dxs);
  assign c_ty = clamp(SUM_W'(f_ctl.ty) + dys);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv_v[QUO_W];
    end
    if (en) begin
      rsp.new_from_x <= c_fx[COORD_W-1:0];
      rsp.new_from_y <= c_fy[COORD_W-1:0];
      rsp.new_to_x   <= c_tx[COORD_W-1:0];
      rsp.new_to_y   <= c_ty[COORD_W-1:0];
      rsp.saturated  <= c_fx[COORD_W] | c_fy[COORD_W] | c_tx[COORD_W] | c_ty[COORD_W];
    end
  end

  // a zero root means coincident endpoints and nothing else
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    sr_v[LEN_W] |-> ((len == '0) == (sr_item[LEN_W].vx == '0 && sr_item[LEN_W].vy == '0)))
    else $error("root is zero without coincident endpoints");

  // divider leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_v[QUO_W] && !f_ctl.zero) |->
      (dv_remx[QUO_W] < DV_W'(f_ctl.dvs) && dv_remy[QUO_W] < DV_W'(f_ctl.dvs)))
    else $error("division remainder not reduced");

  // a held result stays valid and its new_to_x stays put while the pipeline is frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.new_to_x)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
